// ----- rtl/http_request_framer_macros.svh -----
// Assertion macros shared by the framer checker.
// No dependencies; include by bare file name where assertions are written.
`ifndef HTTP_REQUEST_FRAMER_MACROS_SVH
`define HTTP_REQUEST_FRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Check what follows a cycle with reset asserted
`define HRF_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hrf_pkg.sv -----
// Shared types, constants and helper functions for the request framer.
// No dependencies; compile first.
package hrf_pkg;

    // Widths and limits
    localparam int HDR_CNT_W      = 24;
    localparam int HLEN_W         = 24;
    localparam int BODY_W         = 32;
    localparam int ACC_W          = BODY_W + 1;
    localparam int LPOS_W         = 5;
    localparam int LPOS_MAX       = 19;
    localparam int LEN_PREFIX_LEN = 15;
    localparam int ENC_PREFIX_LEN = 18;
    localparam int TERM_DONE      = 4;

    localparam logic [BODY_W-1:0] MAX_BODY_RST = BODY_W'(4 * 1024 * 1024);
    localparam logic [ACC_W-1:0]  ACC_SAT      = {1'b1, {BODY_W{1'b0}}};
    localparam logic [32:0]       HLEN_MAX     = 33'((64'd1 << HLEN_W) - 64'd1);

    // Character codes
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] ZERO_BYTE  = 8'h30;
    localparam logic [7:0] NINE_BYTE  = 8'h39;

    typedef enum logic {
        PH_HEADER,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        VP_SKIP,
        VP_DIGITS,
        VP_DONE
    } t_value_phase;

    // Control from the framer to the line parser
    typedef struct packed {
        logic step;
        logic restart;
    } t_line_ctl;

    // Line-end events from the line parser
    typedef struct packed {
        logic             len_set;
        logic [ACC_W-1:0] len_value;
        logic             enc_bad;
    } t_line_evt;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'd32;
        end
        return b;
    endfunction

    // "content-length:"
    function automatic logic [7:0] len_prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "transfer-encoding:"
    function automatic logic [7:0] enc_prefix_char(input logic [LPOS_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            5'd17:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Clamp the header byte count to the reported width
    function automatic logic [HLEN_W-1:0] sat_hlen(input logic [HDR_CNT_W-1:0] c);
        logic [32:0] wide;
        wide = 33'(c);
        if (wide > HLEN_MAX) begin
            return HLEN_W'(HLEN_MAX);
        end
        return HLEN_W'(wide);
    endfunction

endpackage

// ----- rtl/hrf_if.sv -----
// Channel interfaces for the request framer: input byte, result, configuration.
// Depends on hrf_pkg for field widths.
interface hrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrf_result_if
    import hrf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              status;
    logic [HLEN_W-1:0] header_length;
    logic [BODY_W-1:0] body_length;

    modport source (output valid, output status, output header_length, output body_length,
                    input ready);
    modport sink   (input valid, input status, input header_length, input body_length,
                    output ready);
endinterface

interface hrf_cfg_if
    import hrf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BODY_W-1:0] max_body_length;

    modport source (output valid, output max_body_length, input ready);
    modport sink   (input valid, input max_body_length, output ready);
endinterface

// ----- rtl/http_request_framer.sv -----
// HTTP request framer, top level. Takes one request byte per beat and reports one
// result per request: complete (with header length and Content-Length body size) or
// malformed (reported at the end of the header). Throughput is one byte per cycle
// while the result slot is free: each byte is registered at the input, then
// processed by the line parser and the framing state, and any result is captured
// in the output register at the end of that processing cycle. The input register
// stalls only while the output register holds a result that has not been taken.
// The body-length limit may be written whenever no request is in flight; there is
// no start-up clearing pass.
// Depends on hrf_pkg, hrf_if and hrf_line_unit.
module http_request_framer
    import hrf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    hrf_byte_if.sink            i_req,
    hrf_result_if.source        o_res,
    hrf_cfg_if.sink             i_cfg
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic [BODY_W-1:0]    r_max_body;
    t_phase               r_phase, n_phase;
    logic [1:0]           r_term, n_term;
    logic [BODY_W-1:0]    r_cl, n_cl;
    logic                 r_malf, n_malf;
    logic [HDR_CNT_W-1:0] r_hcnt, n_hcnt;
    logic [BODY_W-1:0]    r_body_rem, n_body_rem;
    logic                 r_out_valid;
    logic                 r_out_status;
    logic [HLEN_W-1:0]    r_out_hlen;
    logic [BODY_W-1:0]    r_out_blen;

    logic                 w_adv;
    logic [2:0]           w_k;
    logic                 w_term_hit;
    logic                 w_body_done;
    logic [HDR_CNT_W-1:0] w_hcnt_inc;
    logic                 w_emit;
    logic                 w_emit_status;
    logic [BODY_W-1:0]    w_emit_blen;
    logic [HLEN_W-1:0]    w_emit_hlen;
    logic                 w_restart;
    t_line_ctl            w_line_ctl;
    t_line_evt            w_line_evt;

    // Handshakes: advance the processing stage when the result slot is free
    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    // Terminator tracking: CR LF CR LF
    always_comb begin
        if (r_in_byte == CR_BYTE) begin
            w_k = (r_term == 2'd2) ? 3'd3 : 3'd1;
        end else if (r_in_byte == LF_BYTE && (r_term == 2'd1 || r_term == 2'd3)) begin
            w_k = {1'b0, r_term} + 3'd1;
        end else begin
            w_k = 3'd0;
        end
        w_term_hit  = (w_k == 3'(TERM_DONE));
        w_body_done = (r_body_rem <= BODY_W'(1));
        w_hcnt_inc  = (r_hcnt == '1) ? r_hcnt : r_hcnt + 1'b1;
    end

    assign w_line_ctl.step    = w_adv && (r_phase == PH_HEADER);
    assign w_line_ctl.restart = w_restart;

    hrf_line_unit u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_line_ctl),
        .i_byte  (r_in_byte),
        .o_evt   (w_line_evt)
    );

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEADER: begin
                if (w_adv && w_term_hit && !r_malf && r_cl != '0) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (w_adv && w_body_done) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    // Framing datapath and result selection
    always_comb begin
        n_term        = r_term;
        n_cl          = r_cl;
        n_malf        = r_malf;
        n_hcnt        = r_hcnt;
        n_body_rem    = r_body_rem;
        w_emit        = 1'b0;
        w_emit_status = 1'b0;
        w_emit_blen   = '0;
        w_emit_hlen   = sat_hlen(r_hcnt);
        w_restart     = 1'b0;

        if (w_adv) begin
            if (r_phase == PH_HEADER) begin
                n_term      = w_k[1:0];
                n_hcnt      = w_hcnt_inc;
                w_emit_hlen = sat_hlen(w_hcnt_inc);
                if (w_line_evt.len_set) begin
                    n_cl = w_line_evt.len_value[BODY_W-1:0];
                    if (w_line_evt.len_value > {1'b0, r_max_body}) begin
                        n_malf = 1'b1;
                    end
                end
                if (w_line_evt.enc_bad) begin
                    n_malf = 1'b1;
                end
                if (w_term_hit) begin
                    if (r_malf) begin
                        w_emit        = 1'b1;
                        w_emit_status = 1'b1;
                        w_restart     = 1'b1;
                    end else if (r_cl == '0) begin
                        w_emit    = 1'b1;
                        w_restart = 1'b1;
                    end else begin
                        n_body_rem = r_cl;
                    end
                end
            end else begin
                // Count down body bytes
                if (r_body_rem != '0) begin
                    n_body_rem = r_body_rem - 1'b1;
                end
                if (w_body_done) begin
                    w_emit      = 1'b1;
                    w_emit_blen = r_cl;
                    w_restart   = 1'b1;
                end
            end
        end

        // Start over on a fresh request
        if (w_restart) begin
            n_term     = '0;
            n_cl       = '0;
            n_malf     = 1'b0;
            n_hcnt     = '0;
            n_body_rem = '0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.data_byte;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_body <= i_cfg.max_body_length;
        end
    end

    // Framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_term     <= '0;
            r_cl       <= '0;
            r_malf     <= 1'b0;
            r_hcnt     <= '0;
            r_body_rem <= '0;
        end else begin
            r_phase    <= n_phase;
            r_term     <= n_term;
            r_cl       <= n_cl;
            r_malf     <= n_malf;
            r_hcnt     <= n_hcnt;
            r_body_rem <= n_body_rem;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= w_emit_status;
            r_out_hlen   <= w_emit_hlen;
            r_out_blen   <= w_emit_blen;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.header_length = r_out_hlen;
    assign o_res.body_length   = r_out_blen;

endmodule

// ----- rtl/hrf_line_unit.sv -----
// Header line parser: prefix match, value scan and line-end decisions.
// Depends on hrf_pkg (types, prefix tables, constants).
module hrf_line_unit
    import hrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_line_ctl  i_ctl,
    input  logic [7:0] i_byte,
    output t_line_evt  o_evt
);

    logic [LPOS_W-1:0] r_line_pos, n_line_pos;
    logic              r_len_ok, n_len_ok;
    logic              r_enc_ok, n_enc_ok;
    t_value_phase      r_vphase, n_vphase;
    logic              r_skip, n_skip;
    logic [ACC_W-1:0]  r_acc, n_acc;

    logic [7:0]       w_lower;
    logic             w_digit;
    logic             w_blank;
    logic [ACC_W+3:0] w_acc_x10;

    // Classify the byte and form the next decimal value
    always_comb begin
        w_lower   = to_lower(i_byte);
        w_digit   = (i_byte >= ZERO_BYTE) && (i_byte <= NINE_BYTE);
        w_blank   = (i_byte == SPACE_BYTE) || (i_byte == TAB_BYTE);
        w_acc_x10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (ACC_W + 4)'(i_byte[3:0]);
    end

    // Advance line state by one header byte
    always_comb begin
        n_line_pos = r_line_pos;
        n_len_ok   = r_len_ok;
        n_enc_ok   = r_enc_ok;
        n_vphase   = r_vphase;
        n_skip     = r_skip;
        n_acc      = r_acc;
        o_evt      = '0;

        if (i_ctl.step) begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else if (i_byte == CR_BYTE) begin
                // End the line, then start a fresh one
                if (r_line_pos > LPOS_W'(LEN_PREFIX_LEN) && r_len_ok) begin
                    o_evt.len_set   = 1'b1;
                    o_evt.len_value = r_acc;
                end else if (r_line_pos > LPOS_W'(ENC_PREFIX_LEN) && r_enc_ok) begin
                    o_evt.enc_bad = 1'b1;
                end
                n_line_pos = '0;
                n_len_ok   = 1'b1;
                n_enc_ok   = 1'b1;
                n_vphase   = VP_SKIP;
                n_acc      = '0;
                n_skip     = 1'b1;
            end else begin
                if (r_line_pos < LPOS_W'(LEN_PREFIX_LEN)
                        && w_lower != len_prefix_char(r_line_pos[3:0])) begin
                    n_len_ok = 1'b0;
                end
                if (r_line_pos < LPOS_W'(ENC_PREFIX_LEN)
                        && w_lower != enc_prefix_char(r_line_pos)) begin
                    n_enc_ok = 1'b0;
                end
                // Scan the value after the prefix
                if (r_line_pos >= LPOS_W'(LEN_PREFIX_LEN)) begin
                    case (r_vphase)
                        VP_SKIP: begin
                            if (w_digit) begin
                                n_acc    = ACC_W'(i_byte[3:0]);
                                n_vphase = VP_DIGITS;
                            end else if (!w_blank) begin
                                n_vphase = VP_DONE;
                            end
                        end
                        VP_DIGITS: begin
                            if (w_digit) begin
                                if (w_acc_x10 > (ACC_W + 4)'(ACC_SAT)) begin
                                    n_acc = ACC_SAT;
                                end else begin
                                    n_acc = ACC_W'(w_acc_x10);
                                end
                            end else begin
                                n_vphase = VP_DONE;
                            end
                        end
                        default: begin
                            n_vphase = r_vphase;
                        end
                    endcase
                end
                if (r_line_pos < LPOS_W'(LPOS_MAX)) begin
                    n_line_pos = r_line_pos + 1'b1;
                end
            end
        end

        // Drop all line state on a request restart
        if (i_ctl.restart) begin
            n_line_pos = '0;
            n_len_ok   = 1'b1;
            n_enc_ok   = 1'b1;
            n_vphase   = VP_SKIP;
            n_acc      = '0;
            n_skip     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos <= '0;
            r_len_ok   <= 1'b1;
            r_enc_ok   <= 1'b1;
            r_vphase   <= VP_SKIP;
            r_skip     <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_line_pos <= n_line_pos;
            r_len_ok   <= n_len_ok;
            r_enc_ok   <= n_enc_ok;
            r_vphase   <= n_vphase;
            r_skip     <= n_skip;
            r_acc      <= n_acc;
        end
    end

endmodule

// ----- rtl/hrf_checker.sv -----
// Port-level checks on the framer result channel, bound to the top level.
// Depends on hrf_pkg and http_request_framer_macros.svh.
`include "http_request_framer_macros.svh"

module hrf_checker
    import hrf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic              i_res_status,
    input logic [HLEN_W-1:0] i_res_hlen,
    input logic [BODY_W-1:0] i_res_blen
);

    // No result survives reset
    `HRF_ASSERT_RESET(a_reset_clears, i_clk, i_rst_n, !i_res_valid, "result valid after reset")

    // Hold a stalled result beat
    `HRF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_status) && $stable(i_res_hlen) && $stable(i_res_blen), "stalled result changed")

    // A malformed request carries no body
    `HRF_ASSERT_IMPL(a_malf_no_body, i_clk, i_rst_n, i_res_valid && i_res_status, i_res_blen == '0, "malformed result with body length")

    // Every header holds at least its terminator
    `HRF_ASSERT_IMPL(a_hlen_min, i_clk, i_rst_n, i_res_valid, i_res_hlen >= HLEN_W'(TERM_DONE), "header length below terminator size")

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_hlen   (o_res.header_length),
    .i_res_blen   (o_res.body_length)
);
